// File: design/rrq_pkg.sv
package rrq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W          = 8;
  localparam int BURST_W       = 4;
  localparam int QUANT_W       = 4;
  localparam int TIME_W        = 16;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 48;

  localparam logic [BURST_W-1:0] MAX_BURST     = 4'd15;
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 4'd4;
  localparam logic [TIME_W-1:0]  NOW_MAX       = 16'hFFFF;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic latch;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic               started;
  } queue_entry_t;

  typedef struct packed {
    logic              preempted;
    logic [TIME_W-1:0] turnaround_time;
    logic              finished;
    logic [TIME_W-1:0] dispatch_time;
    logic              first_dispatch;
    logic [ID_W-1:0]   running_id;
    logic              idle;
    logic              queue_full;
  } result_t;

endpackage

// File: design/rrq_ctrl.sv
module rrq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rrq_pkg::ctrl_cmd_t cmd_o
);
  import rrq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.latch = 1'b0;
    cmd_o.exec  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/rrq_datapath.sv
module rrq_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrq_pkg::ctrl_cmd_t          cmd_i,
  input  logic                        in_opcode_i,
  input  logic [rrq_pkg::ID_W-1:0]    in_job_id_i,
  input  logic [rrq_pkg::BURST_W-1:0] in_burst_i,
  input  logic                        cfg_we_i,
  input  logic [rrq_pkg::QUANT_W-1:0] cfg_quantum_i,
  output rrq_pkg::result_t            result_o
);
  import rrq_pkg::*;

  queue_entry_t mem [QUEUE_DEPTH];
  queue_entry_t rd_q;

  logic               op_q;
  logic [ID_W-1:0]    id_q;
  logic [BURST_W-1:0] burst_q;

  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               run_valid_q, run_valid_d;
  logic [ID_W-1:0]    run_id_q, run_id_d;
  logic [BURST_W-1:0] run_rem_q, run_rem_d;
  logic [BURST_W-1:0] slice_q, slice_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [QUANT_W-1:0] quantum_q;
  result_t            res_q, res_d;

  logic [QUANT_W-1:0] q_eff;
  logic [TIME_W-1:0]  after;
  logic [BURST_W-1:0] burst_c, cur_rem, rem_n, slice_cur, slice_n;
  logic [ID_W-1:0]    cur_id;
  logic [CNT_W-1:0]   count_mid;
  logic               dispatch, run_act, push;
  queue_entry_t       push_entry;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    q_eff     = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
    after     = (now_q == NOW_MAX) ? NOW_MAX : now_q + 1'b1;
    burst_c   = (burst_q == '0) ? BURST_W'(1) : burst_q;
    if (burst_c > MAX_BURST) begin
      burst_c = MAX_BURST;
    end
    dispatch  = !run_valid_q && (count_q != '0);
    cur_id    = dispatch ? rd_q.id : run_id_q;
    cur_rem   = dispatch ? ((rd_q.remaining == '0) ? BURST_W'(1) : rd_q.remaining)
                         : run_rem_q;
    slice_cur = dispatch ? '0 : slice_q;
    run_act   = run_valid_q || dispatch;
    rem_n     = cur_rem - 1'b1;
    slice_n   = slice_cur + 1'b1;
    count_mid = dispatch ? count_q - 1'b1 : count_q;

    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    run_rem_d   = run_rem_q;
    slice_d     = slice_q;
    now_d       = now_q;
    push        = 1'b0;
    push_entry  = '{id: id_q, remaining: burst_c, started: 1'b0};
    res_d       = '0;

    if (op_q == OP_ADD) begin
      if (count_q == CNT_W'(QUEUE_DEPTH)) begin
        res_d.queue_full = 1'b1;
      end else begin
        push = 1'b1;
      end
    end else begin
      now_d = after;
      if (dispatch) begin
        head_d = next_slot(head_q);
        if (!rd_q.started) begin
          res_d.first_dispatch = 1'b1;
          res_d.dispatch_time  = now_q;
        end
      end
      if (!run_act) begin
        res_d.idle = 1'b1;
      end else begin
        res_d.running_id = cur_id;
        run_id_d         = cur_id;
        run_rem_d        = rem_n;
        run_valid_d      = 1'b1;
        slice_d          = slice_n;
        if (rem_n == '0) begin
          res_d.finished        = 1'b1;
          res_d.turnaround_time = after;
          run_valid_d           = 1'b0;
          slice_d               = '0;
        end else if (slice_n >= q_eff) begin
          slice_d = '0;
          if (count_mid != CNT_W'(QUEUE_DEPTH)) begin
            push            = 1'b1;
            push_entry      = '{id: cur_id, remaining: rem_n, started: 1'b1};
            res_d.preempted = 1'b1;
            run_valid_d     = 1'b0;
          end
        end
      end
    end

    if (push) begin
      tail_d = next_slot(tail_q);
    end
    count_d = push ? count_mid + 1'b1 : count_mid;
    if (op_q == OP_ADD) begin
      count_d = push ? count_q + 1'b1 : count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[head_q];
    if (cmd_i.exec && push) begin
      mem[tail_q] <= push_entry;
    end
    if (cmd_i.latch) begin
      op_q    <= in_opcode_i;
      id_q    <= in_job_id_i;
      burst_q <= in_burst_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_rem_q   <= '0;
      slice_q     <= '0;
      now_q       <= '0;
      quantum_q   <= QUANTUM_RESET;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_quantum_i;
      end
      if (cmd_i.exec) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        run_valid_q <= run_valid_d;
        run_id_q    <= run_id_d;
        run_rem_q   <= run_rem_d;
        slice_q     <= slice_d;
        now_q       <= now_d;
      end
    end
  end

  assign result_o = res_q;

endmodule

// File: design/round_robin_quantum_scheduler_core.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: job_id, burst; tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: one result per item
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i: quantum
//
// Each item passes through three steps: accept, queue head read, execute and load the result.
// The registered read of the ready queue memory at the head pointer adds the queue head read step.
// The next item is taken while a result waits in the output register.
// Execute holds while the output register is full and not being drained.
// Reset clears pointers, counters, running job and time; quantum resets to 4.
module round_robin_quantum_scheduler_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // job_id[7:0], burst[11:8], zero fill
  input  logic [rrq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // queue_full[0], idle[1], running_id[9:2], first_dispatch[10],
  // dispatch_time[26:11], finished[27], turnaround_time[43:28], preempted[44]
  output logic [rrq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rrq_pkg::QUANT_W-1:0]     cfg_data_i
);
  import rrq_pkg::*;

  ctrl_cmd_t cmd;
  result_t   result;

  assign cfg_ready_o = 1'b1;

  rrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  rrq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_opcode_i   (s_axis_tuser[0]),
    .in_job_id_i   (s_axis_tdata[ID_W-1:0]),
    .in_burst_i    (s_axis_tdata[ID_W+BURST_W-1:ID_W]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_quantum_i (cfg_data_i),
    .result_o      (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous transfer in flight");

  a_exec_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> m_axis_tvalid)
    else $error("executed item produced no result");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({result.queue_full, result.idle,
                                result.finished, result.preempted}))
    else $error("conflicting result flags");

  a_exec_needs_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 !s_axis_tready)
    else $error("execute skipped queue read cycle");

endmodule
